// ===== hw/rtl/odwt_pkg.sv =====
package odwt_pkg;

    // default field widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    // configuration registers
    localparam int            CFG_W        = 12;
    localparam logic [11:0]   RADIUS_RESET = 12'd550;
    localparam logic [3:0]    OWN_RESET    = 4'd0;
    localparam logic          CFG_RADIUS   = 1'b0;
    localparam logic          CFG_OWN      = 1'b1;

    // item kinds
    localparam logic [1:0] FUNC_START    = 2'd0;
    localparam logic [1:0] FUNC_TEAMMATE = 2'd1;
    localparam logic [1:0] FUNC_OPPONENT = 2'd2;

    // multiplier operand selects
    localparam logic [3:0] OPD_PX   = 4'd0;
    localparam logic [3:0] OPD_PY   = 4'd1;
    localparam logic [3:0] OPD_TX   = 4'd2;
    localparam logic [3:0] OPD_TY   = 4'd3;
    localparam logic [3:0] OPD_BX   = 4'd4;
    localparam logic [3:0] OPD_BY   = 4'd5;
    localparam logic [3:0] OPD_D    = 4'd6;
    localparam logic [3:0] OPD_R    = 4'd7;
    localparam logic [3:0] OPD_C    = 4'd8;
    localparam logic [3:0] OPD_S    = 4'd9;
    localparam logic [3:0] OPD_CMH  = 4'd10;
    localparam logic [3:0] OPD_CML  = 4'd11;
    localparam logic [3:0] OPD_DOTH = 4'd12;
    localparam logic [3:0] OPD_DOTL = 4'd13;

    // accumulator operations
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_LOAD  = 3'd1;
    localparam logic [2:0] ACC_ADD   = 3'd2;
    localparam logic [2:0] ACC_SUB   = 3'd3;
    localparam logic [2:0] ACC_SHADD = 3'd4;

    // register saves
    localparam logic [3:0] SV_NONE  = 4'd0;
    localparam logic [3:0] SV_S     = 4'd1;
    localparam logic [3:0] SV_START = 4'd2;
    localparam logic [3:0] SV_DOT   = 4'd3;
    localparam logic [3:0] SV_CROSS = 4'd4;
    localparam logic [3:0] SV_D     = 4'd5;
    localparam logic [3:0] SV_H     = 4'd6;
    localparam logic [3:0] SV_C     = 4'd7;
    localparam logic [3:0] SV_SN    = 4'd8;
    localparam logic [3:0] SV_NX    = 4'd9;
    localparam logic [3:0] SV_NY    = 4'd10;
    localparam logic [3:0] SV_BEST  = 4'd11;

    // square root sources
    localparam logic [1:0] SQ_S   = 2'd0;
    localparam logic [1:0] SQ_BD  = 2'd1;
    localparam logic [1:0] SQ_ACC = 2'd2;

    // divider numerator sources
    localparam logic DV_D = 1'b0;
    localparam logic DV_R = 1'b1;

    // output load modes
    localparam logic [1:0] OUT_NONE  = 2'd0;
    localparam logic [1:0] OUT_PLAIN = 2'd1;
    localparam logic [1:0] OUT_DEFL  = 2'd2;

    typedef struct packed {
        logic       capture;
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic [2:0] acc_op;
        logic [3:0] save;
        logic       sq_start;
        logic [1:0] sq_src;
        logic       dv_start;
        logic       dv_src;
        logic [1:0] out_mode;
    } t_cmd;

    typedef struct packed {
        logic start_item;
        logic obstacle;
        logic last;
        logic cand;
        logic en_found;
        logic left;
        logic sq_busy;
        logic dv_busy;
    } t_sts;

endpackage

// ===== hw/rtl/obstacle_deflect_walk_target.sv =====
// Deflects a walk target around the nearest robot that blocks it. A frame is a
// start word (target and enable) followed by robot words; the word marked last
// yields one result with the avoid flag and the new target. Words are taken one
// at a time. A robot word that passes the seen/own-number filter is worked by the
// bit-serial square root (COORD_WIDTH+1 steps) and the shared multiply-accumulate
// unit. A last word that deflects adds two square roots and two divisions, the
// latter in the restoring divider (COORD_WIDTH+ANGLE_WIDTH steps each). The result
// sits in an output register, so the next frame may start while it waits to be
// taken. Configuration writes (radius, own number) take effect at once; the user
// must make them only while the block is idle; the block does not enforce this.
module obstacle_deflect_walk_target #(
    parameter int COORD_WIDTH = odwt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = odwt_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [odwt_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_func,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic [3:0]                    i_player_number,
    input  logic                          i_seen_now,
    input  logic                          i_enable,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_avoid,
    output logic signed [COORD_WIDTH-1:0] o_new_x,
    output logic signed [COORD_WIDTH-1:0] o_new_y
);
    import odwt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    odwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    odwt_dp #(.CW(COORD_WIDTH), .AW(ANGLE_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (i_func),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_player_number (i_player_number),
        .i_seen_now      (i_seen_now),
        .i_enable        (i_enable),
        .i_last          (i_last),
        .o_avoid         (o_avoid),
        .o_new_x         (o_new_x),
        .o_new_y         (o_new_y)
    );

    // an accepted word raises the input stall in the cycle after it
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on consecutive cycles");

    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a result is only raised while a word is in work
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in work");
endmodule

// ===== hw/rtl/odwt_sqrt.sv =====
module odwt_sqrt #(
    parameter int IN_W = 34
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IN_W-1:0]     i_radicand,
    output logic                o_busy,
    output logic [IN_W/2-1:0]   o_root
);
    localparam int RW = IN_W / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [IN_W-1:0]  r_rad;
    logic [RW:0]      r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic [RW+2:0]    rem_sh;
    logic [RW+2:0]    trial;
    logic             take;

    // one root bit per step from two radicand bits
    assign rem_sh = {r_rem, r_rad[IN_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad <= {r_rad[IN_W-3:0], 2'b00};
            if (take) begin
                r_rem  <= RW'(0) + (rem_sh[RW:0] - trial[RW:0]);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[RW:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;
endmodule

// ===== hw/rtl/odwt_div.sv =====
module odwt_div #(
    parameter int NW = 32,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      rem_sh;
    logic             take;

    // restoring division, one quotient bit per step
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (take) begin
                r_rem <= DW'(rem_sh - {1'b0, r_den});
            end else begin
                r_rem <= rem_sh[DW-1:0];
            end
            r_num <= {r_num[NW-2:0], take};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_num;
endmodule

// ===== hw/rtl/odwt_dp.sv =====
module odwt_dp #(
    parameter int CW = 16,
    parameter int AW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  odwt_pkg::t_cmd        i_cmd,
    output odwt_pkg::t_sts        o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_index,
    input  logic [11:0]           i_cfg_wdata,
    input  logic [1:0]            i_func,
    input  logic signed [CW-1:0]  i_pos_x,
    input  logic signed [CW-1:0]  i_pos_y,
    input  logic [3:0]            i_player_number,
    input  logic                  i_seen_now,
    input  logic                  i_enable,
    input  logic                  i_last,
    output logic                  o_avoid,
    output logic signed [CW-1:0]  o_new_x,
    output logic signed [CW-1:0]  o_new_y
);
    import odwt_pkg::*;

    localparam int F   = AW - 2;
    localparam int SW  = 2 * CW;
    localparam int RW  = CW + 1;
    localparam int SQW = 2 * CW + 2;
    localparam int MW  = (CW + 2 > F + 2) ? CW + 2 : F + 2;
    localparam int ACW = (3 * CW + 2 > 2 * MW + 2) ? 3 * CW + 2 : 2 * MW + 2;
    localparam int NW  = CW + F + 2;

    // configuration
    logic [11:0] r_radius;
    logic [3:0]  r_own;

    // captured item
    logic [1:0]           r_func;
    logic signed [CW-1:0] r_px, r_py;
    logic [3:0]           r_pn;
    logic                 r_seen, r_en_in, r_last;

    // frame state
    logic signed [CW-1:0] r_tx, r_ty, r_bx, r_by;
    logic [SW-1:0]        r_bd;
    logic                 r_left, r_found, r_en;

    // work registers
    logic [SW-1:0]         r_s;
    logic signed [SW:0]    r_dot, r_cross;
    logic [RW-1:0]         r_d, r_h;
    logic [F:0]            r_c, r_sn;
    logic signed [CW-1:0]  r_nx, r_ny;
    logic signed [ACW-1:0] r_acc;

    logic signed [MW-1:0]   op_a, op_b;
    logic signed [2*MW-1:0] prod;
    logic signed [ACW-1:0]  prod_x;
    logic [SW:0]            cm;
    logic [SQW-1:0]         sq_in;
    logic [RW-1:0]          sq_root;
    logic                   sq_busy, dv_busy;
    logic [NW-1:0]          dv_num, dv_quot;
    logic [F:0]             frac_q;
    logic                   cand;
    logic                   acc_neg;
    logic [ACW-1:0]         rnd_mag, rnd_q;
    logic signed [ACW-1:0]  rnd_v;
    logic signed [CW-1:0]   rnd_sat;

    localparam logic signed [ACW-1:0] CMAX = {{(ACW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [ACW-1:0] CMIN = {{(ACW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [ACW-1:0]        HALF = ACW'(1) << (F - 1);
    localparam logic [F:0]            UNITY = (F+1)'(1) << F;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_own    <= OWN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_wdata;
                CFG_OWN:    r_own    <= i_cfg_wdata[3:0];
                default:    r_own    <= r_own;
            endcase
        end
    end

    // magnitude of the cross product
    assign cm = r_cross[SW] ? SW'(0) - r_cross : r_cross;

    // select one multiplier operand
    function automatic logic signed [MW-1:0] pick(input logic [3:0] sel,
        input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
        input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty,
        input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
        input logic [RW-1:0] d, input logic [11:0] rad,
        input logic [F:0] c, input logic [F:0] sn,
        input logic [SW:0] cmv, input logic signed [SW:0] dot);
        logic signed [MW-1:0] v;
        case (sel)
            OPD_PX:   v = {{(MW-CW){px[CW-1]}}, px};
            OPD_PY:   v = {{(MW-CW){py[CW-1]}}, py};
            OPD_TX:   v = {{(MW-CW){tx[CW-1]}}, tx};
            OPD_TY:   v = {{(MW-CW){ty[CW-1]}}, ty};
            OPD_BX:   v = {{(MW-CW){bx[CW-1]}}, bx};
            OPD_BY:   v = {{(MW-CW){by[CW-1]}}, by};
            OPD_D:    v = {{(MW-RW){1'b0}}, d};
            OPD_R:    v = {{(MW-12){1'b0}}, rad};
            OPD_C:    v = {{(MW-F-1){1'b0}}, c};
            OPD_S:    v = {{(MW-F-1){1'b0}}, sn};
            OPD_CMH:  v = {{(MW-CW){1'b0}}, cmv[SW-1:CW]};
            OPD_CML:  v = {{(MW-CW){1'b0}}, cmv[CW-1:0]};
            OPD_DOTH: v = {{(MW-CW){1'b0}}, dot[SW-1:CW]};
            OPD_DOTL: v = {{(MW-CW){1'b0}}, dot[CW-1:0]};
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign op_a = pick(i_cmd.a_sel, r_px, r_py, r_tx, r_ty, r_bx, r_by, r_d, r_radius,
                       r_c, r_sn, cm, r_dot);
    assign op_b = pick(i_cmd.b_sel, r_px, r_py, r_tx, r_ty, r_bx, r_by, r_d, r_radius,
                       r_c, r_sn, cm, r_dot);
    assign prod   = op_a * op_b;
    assign prod_x = {{(ACW-2*MW){prod[2*MW-1]}}, prod};

    // accumulate products
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD:  r_acc <= prod_x;
            ACC_ADD:   r_acc <= r_acc + prod_x;
            ACC_SUB:   r_acc <= r_acc - prod_x;
            ACC_SHADD: r_acc <= (r_acc <<< CW) + prod_x;
            default:   r_acc <= r_acc;
        endcase
    end

    // round the accumulator half away from zero and clamp
    assign acc_neg = r_acc[ACW-1];
    assign rnd_mag = acc_neg ? ACW'(0) - r_acc : r_acc;
    assign rnd_q   = (rnd_mag + HALF) >> F;
    assign rnd_v   = acc_neg ? ACW'(0) - rnd_q : rnd_q;
    assign rnd_sat = (rnd_v > CMAX) ? CMAX[CW-1:0] :
                     (rnd_v < CMIN) ? CMIN[CW-1:0] : rnd_v[CW-1:0];

    // blocker test: nearer, in front, and lateral offset under the radius
    assign cand = (r_s < r_bd) && !r_dot[SW] && (r_dot != '0)
               && !r_acc[ACW-1] && (r_acc != '0);

    // iterative units
    always_comb begin
        case (i_cmd.sq_src)
            SQ_S:    sq_in = {2'b00, r_s};
            SQ_BD:   sq_in = {2'b00, r_bd};
            default: sq_in = r_acc[SQW-1:0];
        endcase
    end

    assign dv_num = (i_cmd.dv_src == DV_R)
                  ? NW'({r_radius, {F{1'b0}}}) + NW'(r_h >> 1)
                  : NW'({r_d, {F{1'b0}}}) + NW'(r_h >> 1);
    assign frac_q = (r_h == '0) ? UNITY : dv_quot[F:0];

    odwt_sqrt #(.IN_W(SQW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_start),
        .i_radicand (sq_in),
        .o_busy     (sq_busy),
        .o_root     (sq_root)
    );

    odwt_div #(.NW(NW), .DW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dv_start),
        .i_num   (dv_num),
        .i_den   (r_h),
        .o_busy  (dv_busy),
        .o_quot  (dv_quot)
    );

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_pn    <= i_player_number;
            r_seen  <= i_seen_now;
            r_en_in <= i_enable;
            r_last  <= i_last;
        end
    end

    // frame state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx    <= '0;
            r_ty    <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_bd    <= '0;
            r_left  <= 1'b0;
            r_found <= 1'b0;
            r_en    <= 1'b0;
        end else begin
            case (i_cmd.save)
                SV_START: begin
                    r_tx    <= r_px;
                    r_ty    <= r_py;
                    r_en    <= r_en_in;
                    r_found <= 1'b0;
                    r_bd    <= r_acc[SW-1:0];
                end
                SV_BEST: begin
                    if (cand) begin
                        r_bd    <= r_s;
                        r_bx    <= r_px;
                        r_by    <= r_py;
                        r_left  <= !r_cross[SW] && (r_cross != '0);
                        r_found <= 1'b1;
                    end
                end
                default: r_found <= r_found;
            endcase
        end
    end

    // work register saves
    always_ff @(posedge i_clk) begin
        case (i_cmd.save)
            SV_S:     r_s     <= r_acc[SW-1:0];
            SV_DOT:   r_dot   <= r_acc[SW:0];
            SV_CROSS: r_cross <= r_acc[SW:0];
            SV_D:     r_d     <= sq_root;
            SV_H:     r_h     <= sq_root;
            SV_C:     r_c     <= frac_q;
            SV_SN:    r_sn    <= frac_q;
            SV_NX:    r_nx    <= rnd_sat;
            SV_NY:    r_ny    <= rnd_sat;
            default:  r_s     <= r_s;
        endcase
    end

    // output word
    always_ff @(posedge i_clk) begin
        case (i_cmd.out_mode)
            OUT_PLAIN: begin
                o_avoid <= 1'b0;
                o_new_x <= r_tx;
                o_new_y <= r_ty;
            end
            OUT_DEFL: begin
                o_avoid <= 1'b1;
                o_new_x <= r_nx;
                o_new_y <= r_ny;
            end
            default: o_avoid <= o_avoid;
        endcase
    end

    // status to the controller
    assign o_sts.start_item = (r_func == FUNC_START);
    assign o_sts.obstacle   = r_seen && ((r_func == FUNC_OPPONENT)
                            || ((r_func == FUNC_TEAMMATE) && (r_pn != r_own)));
    assign o_sts.last       = r_last;
    assign o_sts.cand       = cand;
    assign o_sts.en_found   = r_en && r_found;
    assign o_sts.left       = r_left;
    assign o_sts.sq_busy    = sq_busy;
    assign o_sts.dv_busy    = dv_busy;
endmodule

// ===== hw/rtl/odwt_ctrl.sv =====
module odwt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  odwt_pkg::t_sts i_sts,
    output odwt_pkg::t_cmd o_cmd
);
    import odwt_pkg::*;

    localparam logic [5:0] ST_IDLE = 6'd0;
    localparam logic [5:0] ST_DISP = 6'd1;
    localparam logic [5:0] ST_T1   = 6'd2;
    localparam logic [5:0] ST_T2   = 6'd3;
    localparam logic [5:0] ST_T3   = 6'd4;
    localparam logic [5:0] ST_O1   = 6'd5;
    localparam logic [5:0] ST_O2   = 6'd6;
    localparam logic [5:0] ST_O3   = 6'd7;
    localparam logic [5:0] ST_O4   = 6'd8;
    localparam logic [5:0] ST_O5   = 6'd9;
    localparam logic [5:0] ST_O6   = 6'd10;
    localparam logic [5:0] ST_O7   = 6'd11;
    localparam logic [5:0] ST_O8   = 6'd12;
    localparam logic [5:0] ST_O9   = 6'd13;
    localparam logic [5:0] ST_O10  = 6'd14;
    localparam logic [5:0] ST_O11  = 6'd15;
    localparam logic [5:0] ST_O12  = 6'd16;
    localparam logic [5:0] ST_O13  = 6'd17;
    localparam logic [5:0] ST_FIN  = 6'd18;
    localparam logic [5:0] ST_L1   = 6'd19;
    localparam logic [5:0] ST_L2   = 6'd20;
    localparam logic [5:0] ST_L3   = 6'd21;
    localparam logic [5:0] ST_L4   = 6'd22;
    localparam logic [5:0] ST_L5   = 6'd23;
    localparam logic [5:0] ST_L6   = 6'd24;
    localparam logic [5:0] ST_L7   = 6'd25;
    localparam logic [5:0] ST_L8   = 6'd26;
    localparam logic [5:0] ST_L9   = 6'd27;
    localparam logic [5:0] ST_L10  = 6'd28;
    localparam logic [5:0] ST_L11  = 6'd29;
    localparam logic [5:0] ST_L12  = 6'd30;
    localparam logic [5:0] ST_L13  = 6'd31;
    localparam logic [5:0] ST_L14  = 6'd32;
    localparam logic [5:0] ST_L15  = 6'd33;
    localparam logic [5:0] ST_EMP  = 6'd34;
    localparam logic [5:0] ST_EMD  = 6'd35;

    logic [5:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // sequence the datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.start_item) n_state = ST_T1;
                else if (i_sts.obstacle) n_state = ST_O1;
                else n_state = ST_FIN;
            end
            // start word: squared target length
            ST_T1: begin
                o_cmd.a_sel = OPD_PX; o_cmd.b_sel = OPD_PX; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_T2;
            end
            ST_T2: begin
                o_cmd.a_sel = OPD_PY; o_cmd.b_sel = OPD_PY; o_cmd.acc_op = ACC_ADD;
                n_state = ST_T3;
            end
            ST_T3: begin
                o_cmd.save = SV_START;
                n_state = ST_FIN;
            end
            // obstacle word: distance, dot, cross, lateral test
            ST_O1: begin
                o_cmd.a_sel = OPD_PX; o_cmd.b_sel = OPD_PX; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_O2;
            end
            ST_O2: begin
                o_cmd.a_sel = OPD_PY; o_cmd.b_sel = OPD_PY; o_cmd.acc_op = ACC_ADD;
                n_state = ST_O3;
            end
            ST_O3: begin
                o_cmd.save = SV_S;
                o_cmd.a_sel = OPD_TX; o_cmd.b_sel = OPD_PX; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_O4;
            end
            ST_O4: begin
                o_cmd.a_sel = OPD_TY; o_cmd.b_sel = OPD_PY; o_cmd.acc_op = ACC_ADD;
                n_state = ST_O5;
            end
            ST_O5: begin
                o_cmd.save = SV_DOT;
                o_cmd.a_sel = OPD_TX; o_cmd.b_sel = OPD_PY; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_O6;
            end
            ST_O6: begin
                o_cmd.a_sel = OPD_TY; o_cmd.b_sel = OPD_PX; o_cmd.acc_op = ACC_SUB;
                n_state = ST_O7;
            end
            ST_O7: begin
                o_cmd.save = SV_CROSS;
                o_cmd.sq_start = 1'b1; o_cmd.sq_src = SQ_S;
                n_state = ST_O8;
            end
            ST_O8: begin
                if (!i_sts.sq_busy) begin
                    o_cmd.save = SV_D;
                    n_state = ST_O9;
                end
            end
            ST_O9: begin
                o_cmd.a_sel = OPD_R; o_cmd.b_sel = OPD_DOTH; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_O10;
            end
            ST_O10: begin
                o_cmd.a_sel = OPD_D; o_cmd.b_sel = OPD_CMH; o_cmd.acc_op = ACC_SUB;
                n_state = ST_O11;
            end
            ST_O11: begin
                o_cmd.a_sel = OPD_R; o_cmd.b_sel = OPD_DOTL; o_cmd.acc_op = ACC_SHADD;
                n_state = ST_O12;
            end
            ST_O12: begin
                o_cmd.a_sel = OPD_D; o_cmd.b_sel = OPD_CML; o_cmd.acc_op = ACC_SUB;
                n_state = ST_O13;
            end
            ST_O13: begin
                o_cmd.save = SV_BEST;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.last) n_state = ST_IDLE;
                else if (i_sts.en_found) n_state = ST_L1;
                else n_state = ST_EMP;
            end
            // last word: opening angle and turned target
            ST_L1: begin
                o_cmd.sq_start = 1'b1; o_cmd.sq_src = SQ_BD;
                n_state = ST_L2;
            end
            ST_L2: begin
                if (!i_sts.sq_busy) begin
                    o_cmd.save = SV_D;
                    n_state = ST_L3;
                end
            end
            ST_L3: begin
                o_cmd.a_sel = OPD_D; o_cmd.b_sel = OPD_D; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_L4;
            end
            ST_L4: begin
                o_cmd.a_sel = OPD_R; o_cmd.b_sel = OPD_R; o_cmd.acc_op = ACC_ADD;
                n_state = ST_L5;
            end
            ST_L5: begin
                o_cmd.sq_start = 1'b1; o_cmd.sq_src = SQ_ACC;
                n_state = ST_L6;
            end
            ST_L6: begin
                if (!i_sts.sq_busy) begin
                    o_cmd.save = SV_H;
                    n_state = ST_L7;
                end
            end
            ST_L7: begin
                o_cmd.dv_start = 1'b1; o_cmd.dv_src = DV_D;
                n_state = ST_L8;
            end
            ST_L8: begin
                if (!i_sts.dv_busy) begin
                    o_cmd.save = SV_C;
                    n_state = ST_L9;
                end
            end
            ST_L9: begin
                o_cmd.dv_start = 1'b1; o_cmd.dv_src = DV_R;
                n_state = ST_L10;
            end
            ST_L10: begin
                if (!i_sts.dv_busy) begin
                    o_cmd.save = SV_SN;
                    n_state = ST_L11;
                end
            end
            ST_L11: begin
                o_cmd.a_sel = OPD_BX; o_cmd.b_sel = OPD_C; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_L12;
            end
            ST_L12: begin
                o_cmd.a_sel = OPD_BY; o_cmd.b_sel = OPD_S;
                o_cmd.acc_op = i_sts.left ? ACC_ADD : ACC_SUB;
                n_state = ST_L13;
            end
            ST_L13: begin
                o_cmd.save = SV_NX;
                o_cmd.a_sel = OPD_BY; o_cmd.b_sel = OPD_C; o_cmd.acc_op = ACC_LOAD;
                n_state = ST_L14;
            end
            ST_L14: begin
                o_cmd.a_sel = OPD_BX; o_cmd.b_sel = OPD_S;
                o_cmd.acc_op = i_sts.left ? ACC_SUB : ACC_ADD;
                n_state = ST_L15;
            end
            ST_L15: begin
                o_cmd.save = SV_NY;
                n_state = ST_EMD;
            end
            // hold until the output register is free
            ST_EMP: begin
                if (out_free) begin
                    o_cmd.out_mode = OUT_PLAIN;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMD: begin
                if (out_free) begin
                    o_cmd.out_mode = OUT_DEFL;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
